// File: sv/cpls_pkg.sv
package cpls_pkg;

  // wheel count is fixed by the per-wheel ports
  localparam int unsigned WHEELS = 4;

  localparam int unsigned CMD_W   = 16;
  localparam int unsigned SPD_W   = 16;
  localparam int unsigned LIM_W   = 16;
  localparam int unsigned COEF_W  = 24;
  localparam int unsigned OFF_W   = 20;
  localparam int unsigned SCALE_W = 17;
  localparam int unsigned KBITS   = 16;

  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [SCALE_W-1:0] SCALE_ONE = SCALE_W'(1) << KBITS;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_EFFORT_COEFF = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_SPEED_COEFF  = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_POWER_OFFSET = CFG_IDX_W'(2);

endpackage

// File: sv/chassis_power_limit_scaler.sv
// channel  | handshake                  | payload
// ---------+----------------------------+----------------------------------------
// in       | in_valid_i / in_ready_o    | command_0..3_i, speed_0..3_i, power_limit_i
// out      | out_valid_o / out_ready_i  | scaled_command_0..3_o, power_scale_o
// cfg      | cfg_we_i (no handshake)    | cfg_index_i, cfg_data_i
//
// one word per cycle sustained while out_ready_i is high
// most of the pipeline is the bitwise scale search: one pipeline stage per bit of k
// each stage holds a valid bit and advances whenever the stage ahead is free,
// so bubbles collapse and a stalled output never drops or repeats a word
// reset clears valid bits and the configuration registers (all zero)
module chassis_power_limit_scaler (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [cpls_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [cpls_pkg::COEF_W-1:0]         cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [cpls_pkg::CMD_W-1:0]   command_0_i,
  input  logic signed [cpls_pkg::CMD_W-1:0]   command_1_i,
  input  logic signed [cpls_pkg::CMD_W-1:0]   command_2_i,
  input  logic signed [cpls_pkg::CMD_W-1:0]   command_3_i,
  input  logic signed [cpls_pkg::SPD_W-1:0]   speed_0_i,
  input  logic signed [cpls_pkg::SPD_W-1:0]   speed_1_i,
  input  logic signed [cpls_pkg::SPD_W-1:0]   speed_2_i,
  input  logic signed [cpls_pkg::SPD_W-1:0]   speed_3_i,
  input  logic [cpls_pkg::LIM_W-1:0]          power_limit_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [cpls_pkg::CMD_W-1:0]   scaled_command_0_o,
  output logic signed [cpls_pkg::CMD_W-1:0]   scaled_command_1_o,
  output logic signed [cpls_pkg::CMD_W-1:0]   scaled_command_2_o,
  output logic signed [cpls_pkg::CMD_W-1:0]   scaled_command_3_o,
  output logic [cpls_pkg::SCALE_W-1:0]        power_scale_o
);

  localparam int unsigned NW   = cpls_pkg::WHEELS;
  localparam int unsigned CW_  = cpls_pkg::CMD_W;
  localparam int unsigned PRW  = 2 * CW_ - 1;                 // |product| <= 2^30
  localparam int unsigned SUMW = PRW + $clog2(NW);
  localparam int unsigned AW   = SUMW + cpls_pkg::COEF_W;
  localparam int unsigned NEGW = AW + 2;                      // signed -c
  localparam int unsigned XW   = SUMW + 68;                   // search arithmetic
  localparam int unsigned KB   = cpls_pkg::KBITS;
  localparam int unsigned SW   = cpls_pkg::SCALE_W;

  typedef logic signed [CW_-1:0] cmd_t;
  typedef logic [PRW-1:0]        prod_t;

  typedef struct packed {
    logic [AW-1:0] a;
    logic [XW-1:0] p;     // a*k^2 + b*k, scaled
    logic [XW-1:0] q;     // 2a*k + b, scaled
    logic [XW-1:0] r;     // -c, scaled
    logic [KB-1:0] k;
    logic          zero;  // limit zero or c > 0
    logic          full;  // k = 1 already fits
  } srch_t;

  // configuration
  logic [cpls_pkg::COEF_W-1:0] eff_q, spd_q;
  logic [cpls_pkg::OFF_W-1:0]  off_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eff_q <= '0;
      spd_q <= '0;
      off_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        cpls_pkg::REG_EFFORT_COEFF: eff_q <= cfg_data_i;
        cpls_pkg::REG_SPEED_COEFF:  spd_q <= cfg_data_i;
        cpls_pkg::REG_POWER_OFFSET: off_q <= cfg_data_i[cpls_pkg::OFF_W-1:0];
        default: ;
      endcase
    end
  end

  // stage enables: a stage loads when it is empty or its successor loads
  logic            en1, en2, en3, en4, en5, en_out;
  logic [KB:0]     en_sr;
  logic            s1_v_q, s2_v_q, s3_v_q, s4_v_q, out_v_q;
  logic [KB:0]     sr_v_q;

  assign en_out = !out_v_q || out_ready_i;
  assign en_sr[KB] = !sr_v_q[KB] || en_out;
  for (genvar i = 0; i < KB; i++) begin : g_en
    assign en_sr[i] = !sr_v_q[i] || en_sr[i+1];
  end
  assign en5 = en_sr[0];
  assign en4 = !s4_v_q || en5;
  assign en3 = !s3_v_q || en4;
  assign en2 = !s2_v_q || en3;
  assign en1 = !s1_v_q || en2;
  assign in_ready_o = en1;

  // stage 1: per-wheel products
  cmd_t  in_cmd [NW];
  cmd_t  in_spd [NW];
  assign in_cmd[0] = command_0_i;
  assign in_cmd[1] = command_1_i;
  assign in_cmd[2] = command_2_i;
  assign in_cmd[3] = command_3_i;
  assign in_spd[0] = speed_0_i;
  assign in_spd[1] = speed_1_i;
  assign in_spd[2] = speed_2_i;
  assign in_spd[3] = speed_3_i;

  cmd_t  s1_cmd_q [NW];
  prod_t s1_cc_q [NW], s1_cs_q [NW], s1_ss_q [NW];
  logic [cpls_pkg::LIM_W-1:0] s1_lim_q;

  for (genvar w = 0; w < NW; w++) begin : g_prod
    logic signed [2*CW_-1:0] cc, cs, ss, cs_abs;
    assign cc     = in_cmd[w] * in_cmd[w];
    assign cs     = in_cmd[w] * in_spd[w];
    assign ss     = in_spd[w] * in_spd[w];
    assign cs_abs = cs[2*CW_-1] ? -cs : cs;
    always_ff @(posedge clk_i) begin
      if (en1) begin
        s1_cmd_q[w] <= in_cmd[w];
        s1_cc_q[w]  <= cc[PRW-1:0];
        s1_cs_q[w]  <= cs_abs[PRW-1:0];
        s1_ss_q[w]  <= ss[PRW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) s1_lim_q <= power_limit_i;
  end

  // stage 2: sums over the wheels
  cmd_t            s2_cmd_q [NW];
  logic [SUMW-1:0] s2_cc_q, s2_cs_q, s2_ss_q;
  logic [cpls_pkg::LIM_W-1:0] s2_lim_q;
  logic [SUMW-1:0] sum_cc, sum_cs, sum_ss;

  always_comb begin
    sum_cc = '0;
    sum_cs = '0;
    sum_ss = '0;
    for (int w = 0; w < NW; w++) begin
      sum_cc = sum_cc + SUMW'(s1_cc_q[w]);
      sum_cs = sum_cs + SUMW'(s1_cs_q[w]);
      sum_ss = sum_ss + SUMW'(s1_ss_q[w]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en2) begin
      s2_cmd_q <= s1_cmd_q;
      s2_cc_q  <= sum_cc;
      s2_cs_q  <= sum_cs;
      s2_ss_q  <= sum_ss;
      s2_lim_q <= s1_lim_q;
    end
  end

  // stage 3: coefficient products, offset plus limit
  cmd_t             s3_cmd_q [NW];
  logic [AW-1:0]    s3_a_q, s3_sv_q;
  logic [SUMW-1:0]  s3_b_q;
  logic signed [NEGW-1:0] s3_ol_q;
  logic             s3_lz_q;
  logic signed [NEGW-1:0] ol_sum;

  assign ol_sum = (NEGW'($signed(off_q)) + NEGW'($signed({1'b0, s2_lim_q}))) <<< 28;

  always_ff @(posedge clk_i) begin
    if (en3) begin
      s3_cmd_q <= s2_cmd_q;
      s3_a_q   <= AW'(eff_q * s2_cc_q);
      s3_sv_q  <= AW'(spd_q * s2_ss_q);
      s3_b_q   <= s2_cs_q;
      s3_ol_q  <= ol_sum;
      s3_lz_q  <= (s2_lim_q == '0);
    end
  end

  // stage 4: -c and its sign
  cmd_t             s4_cmd_q [NW];
  logic [AW-1:0]    s4_a_q;
  logic [SUMW-1:0]  s4_b_q;
  logic [XW-1:0]    s4_r_q;
  logic             s4_zero_q;
  logic signed [NEGW-1:0] cneg;

  assign cneg = s3_ol_q - $signed({2'b00, s3_sv_q});

  always_ff @(posedge clk_i) begin
    if (en4) begin
      s4_cmd_q  <= s3_cmd_q;
      s4_a_q    <= s3_a_q;
      s4_b_q    <= s3_b_q;
      s4_r_q    <= XW'(cneg[NEGW-2:0]) << 40;
      s4_zero_q <= s3_lz_q || cneg[NEGW-1];
    end
  end

  // stage 5: test k = 1 and seed the search
  cmd_t          sr_cmd_q [KB+1][NW];
  srch_t         sr_q [KB+1];
  logic [XW-1:0] p_one;

  assign p_one = (XW'(s4_a_q) << 32) + (XW'(s4_b_q) << 52);

  always_ff @(posedge clk_i) begin
    if (en5) begin
      sr_cmd_q[0]  <= s4_cmd_q;
      sr_q[0].a    <= s4_a_q;
      sr_q[0].p    <= '0;
      sr_q[0].q    <= XW'(s4_b_q) << 36;
      sr_q[0].r    <= s4_r_q;
      sr_q[0].k    <= '0;
      sr_q[0].zero <= s4_zero_q;
      sr_q[0].full <= (p_one <= s4_r_q);
    end
  end

  // search stages: one bit of k each, msb first, using running p and q
  for (genvar i = 0; i < KB; i++) begin : g_bit
    localparam int unsigned J = KB - 1 - i;
    logic [XW-1:0] a_x, t;
    logic          fit;
    srch_t         nxt;
    assign a_x = XW'(sr_q[i].a);
    assign t   = sr_q[i].p + (sr_q[i].q << J) + (a_x << (2 * J));
    assign fit = (t <= sr_q[i].r);
    always_comb begin
      nxt = sr_q[i];
      if (fit) begin
        nxt.p    = t;
        nxt.q    = sr_q[i].q + (a_x << (J + 1));
        nxt.k[J] = 1'b1;
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_sr[i+1]) begin
        sr_cmd_q[i+1] <= sr_cmd_q[i];
        sr_q[i+1]     <= nxt;
      end
    end
  end

  // final stage: pick k and scale the commands
  logic [SW-1:0] k_fin;
  cmd_t          sc_d [NW];
  cmd_t          sc_q [NW];
  logic [SW-1:0] k_q;

  always_comb begin
    if (sr_q[KB].zero) begin
      k_fin = '0;
    end else if (sr_q[KB].full) begin
      k_fin = cpls_pkg::SCALE_ONE;
    end else begin
      k_fin = {1'b0, sr_q[KB].k};
    end
  end

  for (genvar w = 0; w < NW; w++) begin : g_scale
    logic [CW_:0]      mag;
    logic [CW_+SW:0]   prod;
    logic [CW_+1:0]    sc;
    logic              neg;
    assign neg  = sr_cmd_q[KB][w][CW_-1];
    assign mag  = neg ? -{1'b1, sr_cmd_q[KB][w]} : {1'b0, sr_cmd_q[KB][w]};
    assign prod = mag * k_fin;
    assign sc   = prod[CW_+SW:KB];
    assign sc_d[w] = neg ? cmd_t'(-sc) : cmd_t'(sc);
  end

  always_ff @(posedge clk_i) begin
    if (en_out) begin
      sc_q <= sc_d;
      k_q  <= k_fin;
    end
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      s3_v_q  <= 1'b0;
      s4_v_q  <= 1'b0;
      sr_v_q  <= '0;
      out_v_q <= 1'b0;
    end else begin
      if (en1) s1_v_q <= in_valid_i;
      if (en2) s2_v_q <= s1_v_q;
      if (en3) s3_v_q <= s2_v_q;
      if (en4) s4_v_q <= s3_v_q;
      if (en5) sr_v_q[0] <= s4_v_q;
      for (int i = 0; i < KB; i++) begin
        if (en_sr[i+1]) sr_v_q[i+1] <= sr_v_q[i];
      end
      if (en_out) out_v_q <= sr_v_q[KB];
    end
  end

  assign out_valid_o        = out_v_q;
  assign scaled_command_0_o = sc_q[0];
  assign scaled_command_1_o = sc_q[1];
  assign scaled_command_2_o = sc_q[2];
  assign scaled_command_3_o = sc_q[3];
  assign power_scale_o      = k_q;

`ifndef SYNTHESIS
  // scale never exceeds one
  a_scale_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q |-> (k_q <= cpls_pkg::SCALE_ONE))
    else $error("power scale above one");

  // zero scale gives zero commands
  a_zero_cmds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && k_q == '0) |-> (sc_q[0] == '0 && sc_q[1] == '0 &&
                                sc_q[2] == '0 && sc_q[3] == '0))
    else $error("nonzero command with zero scale");

  // the accepted partial power never passes the budget
  a_search_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sr_v_q[KB] |-> (sr_q[KB].p <= sr_q[KB].r))
    else $error("search state exceeds budget");

  // a held result stays put while the output stalls
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && !out_ready_i) |=> (out_v_q && $stable(k_q)))
    else $error("stalled result changed");
`endif

endmodule
